// File: rtl/core/smstat_pkg.sv
// Shared widths, codes and control types for the streaming moment statistics block.
package smstat_pkg;

   // sample and set sizing
   localparam int SAMPLE_WIDTH = 16;
   localparam int MAX_COUNT    = 4096;
   localparam int COUNT_WIDTH  = 13;
   localparam int SUM_WIDTH    = 28;
   localparam int SQSUM_WIDTH  = 43;

   // intermediate products
   localparam int NQ_WIDTH  = 56;
   localparam int DEV_WIDTH = 55;
   localparam int ND_WIDTH  = 26;
   localparam int NDN_WIDTH = 39;

   // shared divider and square root
   localparam int NUM_WIDTH  = 72;
   localparam int DEN_WIDTH  = 39;
   localparam int RAD_WIDTH  = 48;
   localparam int ROOT_WIDTH = 24;

   // result field widths
   localparam int MEAN_WIDTH = 24;
   localparam int MID_WIDTH  = 17;
   localparam int SSD_WIDTH  = 51;
   localparam int VAR_WIDTH  = 40;
   localparam int STAT_WIDTH = 2;

   // status codes
   localparam logic [STAT_WIDTH-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_WIDTH-1:0] STATUS_TOO_FEW  = 2'd1;
   localparam logic [STAT_WIDTH-1:0] STATUS_OVERFLOW = 2'd2;

   // which quantity the shared units are working on
   typedef enum logic [2:0] {
      JOB_MEAN,
      JOB_SSD,
      JOB_SD,
      JOB_SE,
      JOB_RMS
   } job_type;

   // controller states
   typedef enum logic [4:0] {
      ST_ACCUM,
      ST_MUL1,
      ST_MUL2,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_SSD_GO,
      ST_SSD_WAIT,
      ST_SD_GO,
      ST_SD_WAIT,
      ST_SE_GO,
      ST_SE_WAIT,
      ST_RMS_GO,
      ST_RMS_WAIT,
      ST_SQ_SD_GO,
      ST_SQ_SD_WAIT,
      ST_SQ_SE_GO,
      ST_SQ_SE_WAIT,
      ST_SQ_RMS_GO,
      ST_SQ_RMS_WAIT,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic    acc_en;
      logic    acc_clear;
      logic    mul1_en;
      logic    mul2_en;
      logic    div_start;
      logic    div_store;
      logic    sqrt_start;
      logic    sqrt_store;
      logic    out_load;
      job_type job;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic sqrt_done;
   } status_type;

endpackage

// File: rtl/core/smstat_div.sv
// Restoring divider, one quotient bit per cycle.
module smstat_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [smstat_pkg::NUM_WIDTH-1:0]    num,
   input  logic [smstat_pkg::DEN_WIDTH-1:0]    den,
   output logic                                done,
   output logic [smstat_pkg::NUM_WIDTH-1:0]    quot,
   output logic [smstat_pkg::DEN_WIDTH-1:0]    rem
);

   localparam int NW = smstat_pkg::NUM_WIDTH;
   localparam int DW = smstat_pkg::DEN_WIDTH;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;
   logic          ge;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, num_ff[NW-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in = num;
         den_in = den;
         rem_in = '0;
         cnt_in = CW'(NW);
         run_in = 1'b1;
      end else if (run_ff) begin
         num_in = {num_ff[NW-2:0], ge};
         rem_in = ge ? diff[DW-1:0] : shifted[DW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = num_ff;
   assign rem  = rem_ff;

endmodule

// File: rtl/core/smstat_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
module smstat_sqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [smstat_pkg::RAD_WIDTH-1:0]    rad,
   output logic                                done,
   output logic [smstat_pkg::ROOT_WIDTH-1:0]   root
);

   localparam int RW = smstat_pkg::RAD_WIDTH;
   localparam int QW = smstat_pkg::ROOT_WIDTH;
   localparam int CW = $clog2(QW + 1);

   logic [RW-1:0]   rad_ff, rad_in;
   logic [QW+1:0]   rem_ff, rem_in;
   logic [QW-1:0]   root_ff, root_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [QW+1:0]   rem_sh;
   logic [QW+1:0]   trial;
   logic            ge;

   // bring down two radicand bits and try the next root bit
   always_comb begin
      rem_sh  = {rem_ff[QW-1:0], rad_ff[RW-1:RW-2]};
      trial   = {root_ff, 2'b01};
      ge      = (rem_sh >= trial);
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(QW);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rad_in  = {rad_ff[RW-3:0], 2'b00};
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[QW-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/core/smstat_datapath.sv
// Accumulators, products, shared divider and root, and result registers.
module smstat_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  smstat_pkg::cmd_type                       cmd,
   output smstat_pkg::status_type                    stat,
   input  logic                                      csr_write_enable,
   input  logic                                      csr_write_data,
   input  logic signed [smstat_pkg::SAMPLE_WIDTH-1:0] req_value,
   output logic [smstat_pkg::COUNT_WIDTH-1:0]        rsp_count,
   output logic signed [smstat_pkg::SUM_WIDTH-1:0]   rsp_total,
   output logic signed [smstat_pkg::MEAN_WIDTH-1:0]  rsp_mean_q8,
   output logic signed [smstat_pkg::SAMPLE_WIDTH-1:0] rsp_min_value,
   output logic signed [smstat_pkg::SAMPLE_WIDTH-1:0] rsp_max_value,
   output logic signed [smstat_pkg::MID_WIDTH-1:0]   rsp_midrange_halves,
   output logic [smstat_pkg::SSD_WIDTH-1:0]          rsp_squared_deviation_q8,
   output logic [smstat_pkg::VAR_WIDTH-1:0]          rsp_variance_q8,
   output logic [smstat_pkg::ROOT_WIDTH-1:0]         rsp_std_dev_q8,
   output logic [smstat_pkg::ROOT_WIDTH-1:0]         rsp_rms_q8,
   output logic [smstat_pkg::ROOT_WIDTH-1:0]         rsp_std_error_q8,
   output logic [smstat_pkg::STAT_WIDTH-1:0]         rsp_status
);

   localparam int SW  = smstat_pkg::SAMPLE_WIDTH;
   localparam int CTW = smstat_pkg::COUNT_WIDTH;
   localparam int SUW = smstat_pkg::SUM_WIDTH;
   localparam int QSW = smstat_pkg::SQSUM_WIDTH;
   localparam int NQW = smstat_pkg::NQ_WIDTH;
   localparam int DVW = smstat_pkg::DEV_WIDTH;
   localparam int NDW = smstat_pkg::ND_WIDTH;
   localparam int NNW = smstat_pkg::NDN_WIDTH;
   localparam int NW  = smstat_pkg::NUM_WIDTH;
   localparam int DW  = smstat_pkg::DEN_WIDTH;
   localparam int RW  = smstat_pkg::RAD_WIDTH;
   localparam int QW  = smstat_pkg::ROOT_WIDTH;
   localparam int MW  = smstat_pkg::MEAN_WIDTH;
   localparam int MQW = SUW + 8;
   localparam logic signed [SW-1:0] MOST_POS = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] MOST_NEG = {1'b1, {(SW-1){1'b0}}};

   // mode register
   logic mode_ff;

   // running set state
   logic [CTW-1:0]        cnt_ff;
   logic signed [SUW-1:0] sum_ff;
   logic [QSW-1:0]        sq_ff;
   logic signed [SW-1:0]  min_ff;
   logic signed [SW-1:0]  max_ff;
   logic                  ovf_ff;

   // products
   logic [NQW-1:0] nq_ff;
   logic [NQW-1:0] s2_ff;
   logic [NDW-1:0] nd_ff;
   logic [DVW-1:0] dev_ff;
   logic [NNW-1:0] ndn_ff;

   // partial results
   logic [MW-1:0]                    mean_ff;
   logic [smstat_pkg::SSD_WIDTH-1:0] ssd_ff;
   logic [RW-1:0]                    rad_sd_ff;
   logic [RW-1:0]                    rad_se_ff;
   logic [RW-1:0]                    rad_rms_ff;
   logic [QW-1:0]                    sd_ff;
   logic [QW-1:0]                    se_ff;
   logic [QW-1:0]                    rms_ff;

   logic signed [2*SW-1:0] vsq;
   logic [SUW-1:0]         sum_mag;
   logic [CTW-1:0]         dcount;
   logic                   few;
   logic [NW-1:0]          div_num;
   logic [DW-1:0]          div_den;
   logic [NW-1:0]          div_quot;
   logic [DW-1:0]          div_rem;
   logic [RW-1:0]          sq_rad;
   logic [QW-1:0]          sq_root;
   logic [MQW-1:0]         mean_q;
   logic [MQW-1:0]         mean_up;
   logic [MQW-1:0]         mean_full;
   logic [NQW-1:0]         nq_in;
   logic [NQW-1:0]         s2_in;
   logic [NDW-1:0]         nd_in;
   logic [NNW-1:0]         ndn_in;
   logic [NQW-1:0]         dev_diff;

   // shared helpers
   always_comb begin
      vsq      = req_value * req_value;
      sum_mag  = sum_ff[SUW-1] ? SUW'(-sum_ff) : SUW'(sum_ff);
      dcount   = mode_ff ? (cnt_ff - 1'b1) : cnt_ff;
      few      = mode_ff && (cnt_ff < CTW'(2));
      nq_in    = NQW'(cnt_ff) * NQW'(sq_ff);
      s2_in    = NQW'(sum_mag) * NQW'(sum_mag);
      nd_in    = NDW'(cnt_ff) * NDW'(dcount);
      ndn_in   = NNW'(nd_ff) * NNW'(cnt_ff);
      dev_diff = nq_ff - s2_ff;
      mean_q   = div_quot[MQW-1:0];
      mean_up  = mean_q + MQW'(div_rem != '0);
      mean_full = sum_ff[SUW-1] ? (~mean_up + 1'b1) : mean_q;
   end

   // divider operand select
   always_comb begin
      div_num = NW'({dev_ff, 16'd0});
      div_den = DW'(cnt_ff);
      unique case (cmd.job)
         smstat_pkg::JOB_MEAN: div_num = NW'({sum_mag, 8'd0});
         smstat_pkg::JOB_SSD:  div_num = NW'({dev_ff, 8'd0});
         smstat_pkg::JOB_SD:   div_den = DW'(nd_ff);
         smstat_pkg::JOB_SE:   div_den = DW'(ndn_ff);
         smstat_pkg::JOB_RMS:  div_num = NW'({sq_ff, 16'd0});
         default:              div_num = NW'({dev_ff, 16'd0});
      endcase
   end

   // root operand select
   always_comb begin
      unique case (cmd.job)
         smstat_pkg::JOB_SE:  sq_rad = rad_se_ff;
         smstat_pkg::JOB_RMS: sq_rad = rad_rms_ff;
         default:             sq_rad = rad_sd_ff;
      endcase
   end

   smstat_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (stat.div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   smstat_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .rad   (sq_rad),
      .done  (stat.sqrt_done),
      .root  (sq_root)
   );

   // mode register and running set state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         cnt_ff  <= '0;
         sum_ff  <= '0;
         sq_ff   <= '0;
         min_ff  <= MOST_POS;
         max_ff  <= MOST_NEG;
         ovf_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         if (cmd.acc_clear) begin
            cnt_ff <= '0;
            sum_ff <= '0;
            sq_ff  <= '0;
            min_ff <= MOST_POS;
            max_ff <= MOST_NEG;
            ovf_ff <= 1'b0;
         end else if (cmd.acc_en) begin
            if (cnt_ff < CTW'(smstat_pkg::MAX_COUNT)) begin
               cnt_ff <= cnt_ff + 1'b1;
               sum_ff <= sum_ff + SUW'(req_value);
               sq_ff  <= sq_ff + QSW'($unsigned(vsq));
               if (req_value < min_ff) begin
                  min_ff <= req_value;
               end
               if (req_value > max_ff) begin
                  max_ff <= req_value;
               end
            end else begin
               ovf_ff <= 1'b1;
            end
         end
      end
   end

   // products, quotients and roots
   always_ff @(posedge clock) begin
      if (cmd.mul1_en) begin
         nq_ff <= nq_in;
         s2_ff <= s2_in;
         nd_ff <= nd_in;
      end
      if (cmd.mul2_en) begin
         dev_ff <= (nq_ff >= s2_ff) ? dev_diff[DVW-1:0] : '0;
         ndn_ff <= ndn_in;
      end
      if (cmd.div_store) begin
         unique case (cmd.job)
            smstat_pkg::JOB_MEAN: mean_ff    <= mean_full[MW-1:0];
            smstat_pkg::JOB_SSD:  ssd_ff     <= div_quot[smstat_pkg::SSD_WIDTH-1:0];
            smstat_pkg::JOB_SD:   rad_sd_ff  <= div_quot[RW-1:0];
            smstat_pkg::JOB_SE:   rad_se_ff  <= div_quot[RW-1:0];
            smstat_pkg::JOB_RMS:  rad_rms_ff <= div_quot[RW-1:0];
            default:              mean_ff    <= mean_ff;
         endcase
      end
      if (cmd.sqrt_store) begin
         unique case (cmd.job)
            smstat_pkg::JOB_SE:  se_ff  <= sq_root;
            smstat_pkg::JOB_RMS: rms_ff <= sq_root;
            default:             sd_ff  <= sq_root;
         endcase
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_count                <= cnt_ff;
         rsp_total                <= sum_ff;
         rsp_mean_q8              <= mean_ff;
         rsp_min_value            <= min_ff;
         rsp_max_value            <= max_ff;
         rsp_midrange_halves      <= smstat_pkg::MID_WIDTH'(min_ff)
                                     + smstat_pkg::MID_WIDTH'(max_ff);
         rsp_squared_deviation_q8 <= ssd_ff;
         rsp_variance_q8          <= few ? '0 : rad_sd_ff[smstat_pkg::VAR_WIDTH+7:8];
         rsp_std_dev_q8           <= few ? '0 : sd_ff;
         rsp_rms_q8               <= rms_ff;
         rsp_std_error_q8         <= few ? '0 : se_ff;
         if (ovf_ff) begin
            rsp_status <= smstat_pkg::STATUS_OVERFLOW;
         end else if (few) begin
            rsp_status <= smstat_pkg::STATUS_TOO_FEW;
         end else begin
            rsp_status <= smstat_pkg::STATUS_OK;
         end
      end
   end

endmodule

// File: rtl/core/smstat_ctrl.sv
// Sequencer: accumulation, closing computation and result handshake.
module smstat_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  smstat_pkg::status_type stat,
   output smstat_pkg::cmd_type    cmd
);

   smstat_pkg::state_type state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;
   logic                  rsp_free;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smstat_pkg::ST_ACCUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.job        = smstat_pkg::JOB_MEAN;
      req_stall      = (state_ff != smstat_pkg::ST_ACCUM);
      accept         = req_valid && !req_stall;
      rsp_free       = !rsp_valid_ff || !rsp_stall;
      cmd.acc_en     = accept;
      unique case (state_ff)
         smstat_pkg::ST_ACCUM: begin
            if (accept && req_last) begin
               state_in = smstat_pkg::ST_MUL1;
            end
         end
         smstat_pkg::ST_MUL1: begin
            cmd.mul1_en = 1'b1;
            state_in    = smstat_pkg::ST_MUL2;
         end
         smstat_pkg::ST_MUL2: begin
            cmd.mul2_en = 1'b1;
            state_in    = smstat_pkg::ST_MEAN_GO;
         end
         smstat_pkg::ST_MEAN_GO: begin
            cmd.div_start = 1'b1;
            state_in      = smstat_pkg::ST_MEAN_WAIT;
         end
         smstat_pkg::ST_MEAN_WAIT: begin
            if (stat.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = smstat_pkg::ST_SSD_GO;
            end
         end
         smstat_pkg::ST_SSD_GO: begin
            cmd.job       = smstat_pkg::JOB_SSD;
            cmd.div_start = 1'b1;
            state_in      = smstat_pkg::ST_SSD_WAIT;
         end
         smstat_pkg::ST_SSD_WAIT: begin
            cmd.job = smstat_pkg::JOB_SSD;
            if (stat.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = smstat_pkg::ST_SD_GO;
            end
         end
         smstat_pkg::ST_SD_GO: begin
            cmd.job       = smstat_pkg::JOB_SD;
            cmd.div_start = 1'b1;
            state_in      = smstat_pkg::ST_SD_WAIT;
         end
         smstat_pkg::ST_SD_WAIT: begin
            cmd.job = smstat_pkg::JOB_SD;
            if (stat.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = smstat_pkg::ST_SE_GO;
            end
         end
         smstat_pkg::ST_SE_GO: begin
            cmd.job       = smstat_pkg::JOB_SE;
            cmd.div_start = 1'b1;
            state_in      = smstat_pkg::ST_SE_WAIT;
         end
         smstat_pkg::ST_SE_WAIT: begin
            cmd.job = smstat_pkg::JOB_SE;
            if (stat.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = smstat_pkg::ST_RMS_GO;
            end
         end
         smstat_pkg::ST_RMS_GO: begin
            cmd.job       = smstat_pkg::JOB_RMS;
            cmd.div_start = 1'b1;
            state_in      = smstat_pkg::ST_RMS_WAIT;
         end
         smstat_pkg::ST_RMS_WAIT: begin
            cmd.job = smstat_pkg::JOB_RMS;
            if (stat.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = smstat_pkg::ST_SQ_SD_GO;
            end
         end
         smstat_pkg::ST_SQ_SD_GO: begin
            cmd.job        = smstat_pkg::JOB_SD;
            cmd.sqrt_start = 1'b1;
            state_in       = smstat_pkg::ST_SQ_SD_WAIT;
         end
         smstat_pkg::ST_SQ_SD_WAIT: begin
            cmd.job = smstat_pkg::JOB_SD;
            if (stat.sqrt_done) begin
               cmd.sqrt_store = 1'b1;
               state_in       = smstat_pkg::ST_SQ_SE_GO;
            end
         end
         smstat_pkg::ST_SQ_SE_GO: begin
            cmd.job        = smstat_pkg::JOB_SE;
            cmd.sqrt_start = 1'b1;
            state_in       = smstat_pkg::ST_SQ_SE_WAIT;
         end
         smstat_pkg::ST_SQ_SE_WAIT: begin
            cmd.job = smstat_pkg::JOB_SE;
            if (stat.sqrt_done) begin
               cmd.sqrt_store = 1'b1;
               state_in       = smstat_pkg::ST_SQ_RMS_GO;
            end
         end
         smstat_pkg::ST_SQ_RMS_GO: begin
            cmd.job        = smstat_pkg::JOB_RMS;
            cmd.sqrt_start = 1'b1;
            state_in       = smstat_pkg::ST_SQ_RMS_WAIT;
         end
         smstat_pkg::ST_SQ_RMS_WAIT: begin
            cmd.job = smstat_pkg::JOB_RMS;
            if (stat.sqrt_done) begin
               cmd.sqrt_store = 1'b1;
               state_in       = smstat_pkg::ST_OUT;
            end
         end
         smstat_pkg::ST_OUT: begin
            // wait for the result register, then reopen the set
            if (rsp_free) begin
               cmd.out_load  = 1'b1;
               cmd.acc_clear = 1'b1;
               state_in      = smstat_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = smstat_pkg::ST_ACCUM;
         end
      endcase
      // result word handshake
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/core/streaming_moment_statistics.sv
// Streaming moment statistics: top level.
//
// Samples are taken one per clock while a set is open. The word that carries
// last starts the closing computation, during which req_stall is high: the
// products, five divisions on the shared restoring divider (72 quotient
// bits each), three roots on the shared square-root unit, then the load of
// the result register. The result word waits in its own register, so a
// stalled result only holds the next closing word, not the sampling of the
// next set. The user must write sample_mode through csr_write_enable and
// csr_write_data only while no set is closing; the block does not enforce it.
module streaming_moment_statistics (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_write_enable,
   input  logic                                       csr_write_data,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [smstat_pkg::SAMPLE_WIDTH-1:0] req_value,
   input  logic                                       req_last,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [smstat_pkg::COUNT_WIDTH-1:0]         rsp_count,
   output logic signed [smstat_pkg::SUM_WIDTH-1:0]    rsp_total,
   output logic signed [smstat_pkg::MEAN_WIDTH-1:0]   rsp_mean_q8,
   output logic signed [smstat_pkg::SAMPLE_WIDTH-1:0] rsp_min_value,
   output logic signed [smstat_pkg::SAMPLE_WIDTH-1:0] rsp_max_value,
   output logic signed [smstat_pkg::MID_WIDTH-1:0]    rsp_midrange_halves,
   output logic [smstat_pkg::SSD_WIDTH-1:0]           rsp_squared_deviation_q8,
   output logic [smstat_pkg::VAR_WIDTH-1:0]           rsp_variance_q8,
   output logic [smstat_pkg::ROOT_WIDTH-1:0]          rsp_std_dev_q8,
   output logic [smstat_pkg::ROOT_WIDTH-1:0]          rsp_rms_q8,
   output logic [smstat_pkg::ROOT_WIDTH-1:0]          rsp_std_error_q8,
   output logic [smstat_pkg::STAT_WIDTH-1:0]          rsp_status
);

   smstat_pkg::cmd_type    cmd;
   smstat_pkg::status_type stat;

   // sequencer
   smstat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic
   smstat_datapath u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .stat                     (stat),
      .csr_write_enable         (csr_write_enable),
      .csr_write_data           (csr_write_data),
      .req_value                (req_value),
      .rsp_count                (rsp_count),
      .rsp_total                (rsp_total),
      .rsp_mean_q8              (rsp_mean_q8),
      .rsp_min_value            (rsp_min_value),
      .rsp_max_value            (rsp_max_value),
      .rsp_midrange_halves      (rsp_midrange_halves),
      .rsp_squared_deviation_q8 (rsp_squared_deviation_q8),
      .rsp_variance_q8          (rsp_variance_q8),
      .rsp_std_dev_q8           (rsp_std_dev_q8),
      .rsp_rms_q8               (rsp_rms_q8),
      .rsp_std_error_q8         (rsp_std_error_q8),
      .rsp_status               (rsp_status)
   );

endmodule

// File: tb/sv/smstat_checker.sv
// Checker for the streaming moment statistics block: predicts each result word and compares it.
`timescale 1ns / 100ps

module smstat_checker (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_write_enable,
   input  logic                                       csr_write_data,
   input  logic                                       req_valid,
   input  logic                                       req_stall,
   input  logic signed [smstat_pkg::SAMPLE_WIDTH-1:0] req_value,
   input  logic                                       req_last,
   input  logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   input  logic [smstat_pkg::COUNT_WIDTH-1:0]         rsp_count,
   input  logic signed [smstat_pkg::SUM_WIDTH-1:0]    rsp_total,
   input  logic signed [smstat_pkg::MEAN_WIDTH-1:0]   rsp_mean_q8,
   input  logic signed [smstat_pkg::SAMPLE_WIDTH-1:0] rsp_min_value,
   input  logic signed [smstat_pkg::SAMPLE_WIDTH-1:0] rsp_max_value,
   input  logic signed [smstat_pkg::MID_WIDTH-1:0]    rsp_midrange_halves,
   input  logic [smstat_pkg::SSD_WIDTH-1:0]           rsp_squared_deviation_q8,
   input  logic [smstat_pkg::VAR_WIDTH-1:0]           rsp_variance_q8,
   input  logic [smstat_pkg::ROOT_WIDTH-1:0]          rsp_std_dev_q8,
   input  logic [smstat_pkg::ROOT_WIDTH-1:0]          rsp_rms_q8,
   input  logic [smstat_pkg::ROOT_WIDTH-1:0]          rsp_std_error_q8,
   input  logic [smstat_pkg::STAT_WIDTH-1:0]          rsp_status,
   output int                                         fail_count,
   output int                                         pending
);

   localparam int SW  = smstat_pkg::SAMPLE_WIDTH;
   localparam int CTW = smstat_pkg::COUNT_WIDTH;
   localparam int SUW = smstat_pkg::SUM_WIDTH;
   localparam int MNW = smstat_pkg::MEAN_WIDTH;
   localparam int MDW = smstat_pkg::MID_WIDTH;
   localparam int SDW = smstat_pkg::SSD_WIDTH;
   localparam int VRW = smstat_pkg::VAR_WIDTH;
   localparam int RTW = smstat_pkg::ROOT_WIDTH;
   localparam int STW = smstat_pkg::STAT_WIDTH;

   typedef struct {
      logic [CTW-1:0]        count;
      logic signed [SUW-1:0] total;
      logic signed [MNW-1:0] mean_q8;
      logic signed [SW-1:0]  min_value;
      logic signed [SW-1:0]  max_value;
      logic signed [MDW-1:0] midrange;
      logic [SDW-1:0]        ssd_q8;
      logic [VRW-1:0]        var_q8;
      logic [RTW-1:0]        sd_q8;
      logic [RTW-1:0]        rms_q8;
      logic [RTW-1:0]        se_q8;
      logic [STW-1:0]        status;
   } stats_type;

   stats_type stats_q[$];

   // predictor copy of the set accumulators and the mode bit
   bit              divide_by_n_minus_1;
   longint unsigned set_n;
   longint          set_sum;
   longint unsigned set_sq;
   int              set_min, set_max;
   bit              set_overflow;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic bit [127:0] floor_div(bit [127:0] num, longint unsigned den,
                                            int unsigned scale);
      if (den == 0) return '0;
      return (num * scale) / den;
   endfunction

   function automatic bit [127:0] int_sqrt(bit [127:0] x);
      bit [127:0] root, b;
      root = 0;
      b    = 128'd1 << 126;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= root + b) begin
            x    = x - (root + b);
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root;
   endfunction

   task automatic clear_set();
      set_n        = 0;
      set_sum      = 0;
      set_sq       = 0;
      set_min      = 32767;
      set_max      = -32768;
      set_overflow = 0;
   endtask

   // statistics of the closed set
   function automatic stats_type close_stats();
      stats_type       w;
      longint unsigned s_mag, d;
      bit [127:0]      dev;
      longint          a, m;
      bit              too_few;
      s_mag   = (set_sum < 0) ? -set_sum : set_sum;
      dev     = (set_n * set_sq >= s_mag * s_mag) ? 128'(set_n * set_sq - s_mag * s_mag)
                                                  : '0;
      d       = divide_by_n_minus_1 ? ((set_n > 0) ? set_n - 1 : 0) : set_n;
      too_few = divide_by_n_minus_1 && set_n < 2;
      m = 0;
      if (set_n != 0) begin
         a = set_sum * 256;
         m = a / longint'(set_n);
         if ((a % longint'(set_n)) != 0 && a < 0) m--;
      end
      w.count     = CTW'(set_n);
      w.total     = SUW'(set_sum);
      w.mean_q8   = MNW'(m);
      w.min_value = SW'(set_min);
      w.max_value = SW'(set_max);
      w.midrange  = MDW'(set_min + set_max);
      w.ssd_q8    = SDW'(floor_div(dev, set_n, 256));
      w.rms_q8    = RTW'(int_sqrt(floor_div(128'(set_sq), set_n, 65536)));
      w.var_q8    = '0;
      w.sd_q8     = '0;
      w.se_q8     = '0;
      if (!too_few) begin
         w.var_q8 = VRW'(floor_div(dev, set_n * d, 256));
         w.sd_q8  = RTW'(int_sqrt(floor_div(dev, set_n * d, 65536)));
         w.se_q8  = RTW'(int_sqrt(floor_div(dev, set_n * d * set_n, 65536)));
      end
      w.status = set_overflow ? smstat_pkg::STATUS_OVERFLOW
                              : (too_few ? smstat_pkg::STATUS_TOO_FEW : smstat_pkg::STATUS_OK);
      return w;
   endfunction

   task automatic check_field(string name, bit [63:0] exp_v, bit [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      stats_type e;
      if (reset) begin
         divide_by_n_minus_1 = 0;
         clear_set();
         stats_q.delete();
      end else begin
         if (csr_write_enable) divide_by_n_minus_1 = csr_write_data;

         // accumulate one sample word
         if (req_valid && !req_stall) begin
            if (set_n < smstat_pkg::MAX_COUNT) begin
               set_n++;
               set_sum += req_value;
               set_sq  += longint'(req_value) * longint'(req_value);
               if (req_value < set_min) set_min = int'(req_value);
               if (req_value > set_max) set_max = int'(req_value);
            end else begin
               set_overflow = 1;
            end
            if (req_last) begin
               stats_q.push_back(close_stats());
               clear_set();
            end
         end

         // compare the result word against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (stats_q.size() == 0) begin
               $error("result word with no prediction waiting");
               fail_count++;
            end else begin
               e = stats_q.pop_front();
               check_field("count", 64'(e.count), 64'(rsp_count));
               check_field("total", 64'(e.total), 64'(rsp_total));
               check_field("mean_q8", 64'(e.mean_q8), 64'(rsp_mean_q8));
               check_field("min_value", 64'(e.min_value), 64'(rsp_min_value));
               check_field("max_value", 64'(e.max_value), 64'(rsp_max_value));
               check_field("midrange_halves", 64'(e.midrange), 64'(rsp_midrange_halves));
               check_field("squared_deviation_q8", 64'(e.ssd_q8),
                           64'(rsp_squared_deviation_q8));
               check_field("variance_q8", 64'(e.var_q8), 64'(rsp_variance_q8));
               check_field("std_dev_q8", 64'(e.sd_q8), 64'(rsp_std_dev_q8));
               check_field("rms_q8", 64'(e.rms_q8), 64'(rsp_rms_q8));
               check_field("std_error_q8", 64'(e.se_q8), 64'(rsp_std_error_q8));
               check_field("status", 64'(e.status), 64'(rsp_status));
            end
         end
      end
      pending = stats_q.size();
   end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the statistics block.
`timescale 1ns / 100ps

module tb_top;

   localparam int SW          = smstat_pkg::SAMPLE_WIDTH;
   localparam int TAIL_CYCLES = 600;
   localparam int STALL_LIMIT = 20000;
   localparam int LONG_HOLD   = 3000;
   localparam logic signed [SW-1:0] TOP_VALUE    = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] BOTTOM_VALUE = {1'b1, {(SW-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data = 1'b0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SW-1:0] req_value = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [smstat_pkg::COUNT_WIDTH-1:0]        rsp_count;
   logic signed [smstat_pkg::SUM_WIDTH-1:0]   rsp_total;
   logic signed [smstat_pkg::MEAN_WIDTH-1:0]  rsp_mean_q8;
   logic signed [SW-1:0]                      rsp_min_value, rsp_max_value;
   logic signed [smstat_pkg::MID_WIDTH-1:0]   rsp_midrange_halves;
   logic [smstat_pkg::SSD_WIDTH-1:0]          rsp_squared_deviation_q8;
   logic [smstat_pkg::VAR_WIDTH-1:0]          rsp_variance_q8;
   logic [smstat_pkg::ROOT_WIDTH-1:0]         rsp_std_dev_q8, rsp_rms_q8, rsp_std_error_q8;
   logic [smstat_pkg::STAT_WIDTH-1:0]         rsp_status;

   int fail_count, pending;
   bit idle_on = 1;
   bit hold_request = 0;
   int samples_sent;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   streaming_moment_statistics DUT (.*);

   smstat_checker u_checker (.*);

   // watchdog: cycles with no word moving on either channel
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("streaming_moment_statistics regression: fail");
            $finish;
         end
      end
   end

   // result side: random hold-off per word, one long hold on request
   initial begin
      int w;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            w = LONG_HOLD;
         end else begin
            w = idle_on ? $urandom_range(0, 4) : 0;
         end
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_sample(logic signed [SW-1:0] v, logic l);
      int gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= l;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   function automatic logic signed [SW-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return BOTTOM_VALUE;
         1: return TOP_VALUE;
         2: return SW'(int'($urandom_range(0, 16)) - 8);
         default: return SW'($urandom);
      endcase
   endfunction

   task automatic send_random_set(int n);
      for (int i = 0; i < n; i++) send_sample(pick_sample(), i == n - 1);
   endtask

   task automatic send_same_set(logic signed [SW-1:0] v, int n);
      for (int i = 0; i < n; i++) send_sample(v, i == n - 1);
   endtask

   // hold the sender until every result is back, then let the closer finish
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(logic m);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_phase(int target);
      int start, n;
      start = samples_sent;
      while (samples_sent - start < target) begin
         idle_on = ($urandom_range(0, 3) != 0);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
         send_random_set(n);
      end
      idle_on = 1;
   endtask

   initial begin
      samples_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, population mode: single extremes, repeated extremes, mixed ends
      send_same_set(TOP_VALUE, 1);
      send_same_set(BOTTOM_VALUE, 1);
      send_same_set(SW'(0), 1);
      send_same_set(BOTTOM_VALUE, 5);
      send_same_set(TOP_VALUE, 4);
      send_sample(TOP_VALUE, 1'b0);
      send_sample(BOTTOM_VALUE, 1'b1);
      send_sample(SW'(-3), 1'b0);
      send_sample(SW'(2), 1'b0);
      send_sample(SW'(-1), 1'b1);
      drain();

      // directed, sample mode: one sample is too few, two is enough
      set_mode(1'b1);
      send_same_set(SW'(5), 1);
      send_same_set(BOTTOM_VALUE, 1);
      send_sample(BOTTOM_VALUE, 1'b0);
      send_sample(TOP_VALUE, 1'b1);
      send_sample(SW'(7), 1'b0);
      send_sample(SW'(7), 1'b0);
      send_sample(SW'(-9), 1'b1);
      drain();

      // random population mode with one long result hold-off
      set_mode(1'b0);
      hold_request = 1;
      random_phase(180);
      drain();

      // random sample mode
      set_mode(1'b1);
      random_phase(180);
      drain();

      if (fail_count == 0 && pending == 0) begin
         $display("streaming_moment_statistics regression: pass");
      end else begin
         $display("streaming_moment_statistics regression: fail");
      end
      $finish;
   end

endmodule
